// File: design/jdcd_pkg.sv
// ----------------------------------------------------------------------------
// jdcd_pkg
// Shared types and constants for the day number to calendar date pipeline.
// ----------------------------------------------------------------------------
package jdcd_pkg;

    // last day number dated in the Julian calendar (4 Oct 1582)
    localparam logic [31:0] LAST_JULIAN_DAY    = 32'd2299160;
    // day number of 1 March, astronomical year 0 (Gregorian)
    localparam logic [31:0] MARCH_ZERO_OFFSET  = 32'd1721120;

    localparam logic [17:0] DAYS_PER_400_YEARS = 18'd146097;
    localparam logic [17:0] DAYS_PER_4_YEARS   = 18'd1461;
    // floor(2^32 / divisor)
    localparam logic [21:0] RECIP_400_YEARS    = 22'd29398;
    localparam logic [21:0] RECIP_4_YEARS      = 22'd2939744;

    localparam logic [24:0] JULIAN_EPOCH_YEAR  = 25'd4712;

    // Julian four-year cycle, offsets of years 1..3
    localparam logic [10:0] JUL_YEAR1_START    = 11'd366;
    localparam logic [10:0] JUL_YEAR2_START    = 11'd731;
    localparam logic [10:0] JUL_YEAR3_START    = 11'd1096;

    // Gregorian era helpers
    localparam logic [17:0] DAYS_PER_4Y_GREG   = 18'd1460;
    localparam logic [17:0] DAYS_PER_CENTURY   = 18'd36524;
    localparam logic [17:0] LAST_DAY_OF_ERA    = 18'd146096;
    localparam logic [17:0] DAYS_PER_YEAR      = 18'd365;
    // floor(2^18 / divisor)
    localparam logic [24:0] RECIP_1460         = 25'd179;
    localparam logic [26:0] RECIP_365          = 27'd718;

    localparam logic [8:0]  JAN_MARCH_DOY      = 9'd306;
    localparam logic [8:0]  MARCH_1_COMMON     = 9'd59;
    localparam logic [8:0]  MARCH_1_LEAP       = 9'd60;
    localparam logic [8:0]  MAX_DOY            = 9'd365;

    // quotient and remainder of the cycle division
    typedef struct packed {
        logic [14:0] cycle;
        logic [17:0] rem;
        logic        greg;
    } t_cycle;

    // date counted from 1 March; year is two's complement astronomical
    typedef struct packed {
        logic [24:0] year;
        logic [8:0]  doy;
    } t_march_date;

    // first day of each March-based month
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// File: design/jdcd_cycle.sv
// ----------------------------------------------------------------------------
// jdcd_cycle
// Calendar select and division of the day count into 4-year (Julian) or
// 400-year (Gregorian) cycles. Four stages: select, reciprocal multiply,
// back-multiply, correction.
// ----------------------------------------------------------------------------
module jdcd_cycle (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_day_number,
    output logic               o_valid,
    input  logic               i_ready,
    output jdcd_pkg::t_cycle   o_data
);

    typedef struct packed {
        logic [31:0] x;
        logic        greg;
    } t_cyc_a;

    typedef struct packed {
        logic [31:0] x;
        logic [14:0] q0;
        logic        greg;
    } t_cyc_b;

    typedef struct packed {
        logic [18:0] r0;
        logic [14:0] q0;
        logic        greg;
    } t_cyc_c;

    logic [3:0]       r_v;
    logic [3:0]       n_v;
    logic [4:0]       w_rdy;

    t_cyc_a           r_a, n_a;
    t_cyc_b           r_b, n_b;
    t_cyc_c           r_c, n_c;
    jdcd_pkg::t_cycle r_d, n_d;

    logic [21:0]      w_recip;
    logic [53:0]      w_prod;
    logic [17:0]      w_div_b;
    logic [32:0]      w_qc;
    logic [17:0]      w_div_c;
    logic [17:0]      w_div_d;

    always_comb begin
        w_rdy[4] = i_ready;
        for (int k = 3; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign n_v = {r_v[2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < 4; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    // stage a: calendar select
    always_comb begin
        n_a.greg = i_day_number > jdcd_pkg::LAST_JULIAN_DAY;
        n_a.x    = n_a.greg ? i_day_number - jdcd_pkg::MARCH_ZERO_OFFSET : i_day_number;
    end

    // stage b: quotient estimate, low by at most one
    assign w_recip = r_a.greg ? jdcd_pkg::RECIP_400_YEARS : jdcd_pkg::RECIP_4_YEARS;
    assign w_prod  = {22'b0, r_a.x} * {32'b0, w_recip};

    always_comb begin
        n_b.x    = r_a.x;
        n_b.q0   = w_prod[46:32];
        n_b.greg = r_a.greg;
    end

    // stage c: remainder of the estimate
    assign w_div_b = r_b.greg ? jdcd_pkg::DAYS_PER_400_YEARS : jdcd_pkg::DAYS_PER_4_YEARS;
    assign w_qc    = {18'b0, r_b.q0} * {15'b0, w_div_b};

    always_comb begin
        n_c.r0   = r_b.x[18:0] - w_qc[18:0];
        n_c.q0   = r_b.q0;
        n_c.greg = r_b.greg;
    end

    // stage d: correction
    assign w_div_c = r_c.greg ? jdcd_pkg::DAYS_PER_400_YEARS : jdcd_pkg::DAYS_PER_4_YEARS;

    always_comb begin
        n_d.greg = r_c.greg;
        if (r_c.r0 >= {1'b0, w_div_c}) begin
            n_d.cycle = r_c.q0 + 15'd1;
            n_d.rem   = 18'(r_c.r0 - {1'b0, w_div_c});
        end else begin
            n_d.cycle = r_c.q0;
            n_d.rem   = r_c.r0[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_a <= n_a;
        end
        if (w_rdy[1]) begin
            r_b <= n_b;
        end
        if (w_rdy[2]) begin
            r_c <= n_c;
        end
        if (w_rdy[3]) begin
            r_d <= n_d;
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[3];
    assign o_data  = r_d;

    assign w_div_d = r_d.greg ? jdcd_pkg::DAYS_PER_400_YEARS : jdcd_pkg::DAYS_PER_4_YEARS;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] |-> (r_d.rem < w_div_d))
        else $error("cycle remainder not below divisor");

endmodule

// File: design/jdcd_year.sv
// ----------------------------------------------------------------------------
// jdcd_year
// Astronomical year and day of the year counted from 1 March, for both
// calendars. Seven stages; the Julian path rides along the Gregorian one.
// ----------------------------------------------------------------------------
module jdcd_year (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  jdcd_pkg::t_cycle        i_data,
    output logic                    o_valid,
    input  logic                    i_ready,
    output jdcd_pkg::t_march_date   o_data
);

    typedef struct packed {
        logic        greg;
        logic [17:0] doe;
        logic [23:0] era400;
        logic [12:0] cyc_yr;
        logic [10:0] rr;
        logic        leap;
        logic        jadj;
        logic [8:0]  jdoy;
        logic [24:0] jyear;
        logic [6:0]  n1q;
        logic [2:0]  ga;
        logic        gb;
        logic [11:0] r1;
        logic [17:0] t;
        logic [8:0]  yoe;
        logic [9:0]  r2;
        logic [8:0]  doy;
        logic [24:0] year;
    } t_ystage;

    logic [6:0]  r_v;
    logic [6:0]  n_v;
    logic [7:0]  w_rdy;

    t_ystage     r_s0, r_s1, r_s2, r_s3, r_s4, r_s5, r_s6;
    t_ystage     n_s0, n_s1, n_s2, n_s3, n_s4, n_s5, n_s6;

    logic [10:0] w_r11;
    logic [1:0]  w_yoff;
    logic [10:0] w_base;
    logic [24:0] w_n1p;
    logic [17:0] w_n1m;
    logic [8:0]  w_mar;
    logic [26:0] w_tp;
    logic [17:0] w_ym;
    logic [17:0] w_y365;
    logic [1:0]  w_c100;
    logic [17:0] w_doy;

    always_comb begin
        w_rdy[7] = i_ready;
        for (int k = 6; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign n_v = {r_v[5:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < 7; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    // stage 0: era scaling, century count, Julian year in cycle
    assign w_r11 = i_data.rem[10:0];
    assign w_n1p = {7'b0, i_data.rem} * jdcd_pkg::RECIP_1460;

    always_comb begin
        if (w_r11 < jdcd_pkg::JUL_YEAR1_START) begin
            w_yoff = 2'd0;
            w_base = 11'd0;
        end else if (w_r11 < jdcd_pkg::JUL_YEAR2_START) begin
            w_yoff = 2'd1;
            w_base = jdcd_pkg::JUL_YEAR1_START;
        end else if (w_r11 < jdcd_pkg::JUL_YEAR3_START) begin
            w_yoff = 2'd2;
            w_base = jdcd_pkg::JUL_YEAR2_START;
        end else begin
            w_yoff = 2'd3;
            w_base = jdcd_pkg::JUL_YEAR3_START;
        end
    end

    always_comb begin
        n_s0        = '0;
        n_s0.greg   = i_data.greg;
        n_s0.doe    = i_data.rem;
        n_s0.era400 = {9'b0, i_data.cycle} * 24'd400;
        n_s0.n1q    = w_n1p[24:18];
        n_s0.ga     = 3'(i_data.rem >= jdcd_pkg::DAYS_PER_CENTURY)
                    + 3'(i_data.rem >= 18'd73048)
                    + 3'(i_data.rem >= 18'd109572)
                    + 3'(i_data.rem >= jdcd_pkg::LAST_DAY_OF_ERA);
        n_s0.gb     = i_data.rem == jdcd_pkg::LAST_DAY_OF_ERA;
        n_s0.cyc_yr = {i_data.cycle[10:0], w_yoff};
        n_s0.rr     = w_r11 - w_base;
        n_s0.leap   = w_yoff == 2'd0;
    end

    // stage 1: 4-year remainder check, Julian shift to March-based count
    assign w_n1m = {11'b0, r_s0.n1q} * jdcd_pkg::DAYS_PER_4Y_GREG;
    assign w_mar = r_s0.leap ? jdcd_pkg::MARCH_1_LEAP : jdcd_pkg::MARCH_1_COMMON;

    always_comb begin
        n_s1    = r_s0;
        n_s1.r1 = r_s0.doe[11:0] - w_n1m[11:0];
        if (r_s0.rr < {2'b0, w_mar}) begin
            n_s1.jdoy = r_s0.rr[8:0] + jdcd_pkg::JAN_MARCH_DOY;
            n_s1.jadj = 1'b1;
        end else begin
            n_s1.jdoy = 9'(r_s0.rr - {2'b0, w_mar});
            n_s1.jadj = 1'b0;
        end
    end

    // stage 2: leap-adjusted day count, Julian astronomical year
    always_comb begin
        n_s2       = r_s1;
        n_s2.t     = r_s1.doe
                   - 18'(r_s1.n1q + 7'(r_s1.r1 >= jdcd_pkg::DAYS_PER_4Y_GREG[11:0]))
                   + 18'(r_s1.ga) - 18'(r_s1.gb);
        n_s2.jyear = 25'(r_s1.cyc_yr) - jdcd_pkg::JULIAN_EPOCH_YEAR - 25'(r_s1.jadj);
    end

    // stage 3: year estimate
    assign w_tp = {9'b0, r_s2.t} * jdcd_pkg::RECIP_365;

    always_comb begin
        n_s3     = r_s2;
        n_s3.yoe = w_tp[26:18];
    end

    // stage 4: remainder of the estimate
    assign w_ym = {9'b0, r_s3.yoe} * jdcd_pkg::DAYS_PER_YEAR;

    always_comb begin
        n_s4    = r_s3;
        n_s4.r2 = r_s3.t[9:0] - w_ym[9:0];
    end

    // stage 5: year correction
    always_comb begin
        n_s5     = r_s4;
        n_s5.yoe = r_s4.yoe + 9'(r_s4.r2 >= jdcd_pkg::DAYS_PER_YEAR[9:0]);
    end

    // stage 6: day of year, calendar merge
    assign w_y365 = {9'b0, r_s5.yoe} * jdcd_pkg::DAYS_PER_YEAR;
    assign w_c100 = 2'(r_s5.yoe >= 9'd100) + 2'(r_s5.yoe >= 9'd200)
                  + 2'(r_s5.yoe >= 9'd300);
    assign w_doy  = r_s5.doe - w_y365 - 18'(r_s5.yoe[8:2]) + 18'(w_c100);

    always_comb begin
        n_s6 = r_s5;
        if (r_s5.greg) begin
            n_s6.doy  = w_doy[8:0];
            n_s6.year = {1'b0, r_s5.era400 + 24'(r_s5.yoe)};
        end else begin
            n_s6.doy  = r_s5.jdoy;
            n_s6.year = r_s5.jyear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s0 <= n_s0;
        end
        if (w_rdy[1]) begin
            r_s1 <= n_s1;
        end
        if (w_rdy[2]) begin
            r_s2 <= n_s2;
        end
        if (w_rdy[3]) begin
            r_s3 <= n_s3;
        end
        if (w_rdy[4]) begin
            r_s4 <= n_s4;
        end
        if (w_rdy[5]) begin
            r_s5 <= n_s5;
        end
        if (w_rdy[6]) begin
            r_s6 <= n_s6;
        end
    end

    assign o_ready     = w_rdy[0];
    assign o_valid     = r_v[6];
    assign o_data.year = r_s6.year;
    assign o_data.doy  = r_s6.doy;

    a_yoe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[5] && r_s5.greg) |-> (r_s5.yoe < 9'd400))
        else $error("year of era out of range");

    a_doy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[6] |-> (r_s6.doy <= jdcd_pkg::MAX_DOY))
        else $error("day of year out of range");

endmodule

// File: design/jdcd_month.sv
// ----------------------------------------------------------------------------
// jdcd_month
// Month and day from the March-based day of year, then the shift back to a
// January year and the BC conversion. Three stages; the last is the output
// register.
// ----------------------------------------------------------------------------
module jdcd_month (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  jdcd_pkg::t_march_date   i_data,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [4:0]              o_day_of_month,
    output logic [3:0]              o_month_of_year,
    output logic [23:0]             o_year_value,
    output logic                    o_before_christ
);

    typedef struct packed {
        logic [24:0] year;
        logic [8:0]  doy;
        logic [3:0]  mp;
        logic [4:0]  dd;
        logic [3:0]  mm;
        logic [23:0] yv;
        logic        bc;
    } t_mstage;

    logic [2:0]  r_v;
    logic [2:0]  n_v;
    logic [3:0]  w_rdy;

    t_mstage     r_s0, r_s1, r_s2;
    t_mstage     n_s0, n_s1, n_s2;

    logic [8:0]  w_dom;
    logic [24:0] w_neg;

    always_comb begin
        w_rdy[3] = i_ready;
        for (int k = 2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign n_v = {r_v[1:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < 3; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    // stage 0: month index by compare against month starts
    always_comb begin
        n_s0      = '0;
        n_s0.year = i_data.year;
        n_s0.doy  = i_data.doy;
        for (int i = 1; i < 12; i++) begin
            n_s0.mp = n_s0.mp + 4'(i_data.doy >= jdcd_pkg::month_start(4'(i)));
        end
    end

    // stage 1: day, calendar month, January-based year
    assign w_dom = r_s0.doy - jdcd_pkg::month_start(r_s0.mp);

    always_comb begin
        n_s1    = r_s0;
        n_s1.dd = w_dom[4:0] + 5'd1;
        if (r_s0.mp < 4'd10) begin
            n_s1.mm   = r_s0.mp + 4'd3;
            n_s1.year = r_s0.year;
        end else begin
            n_s1.mm   = r_s0.mp - 4'd9;
            n_s1.year = r_s0.year + 25'd1;
        end
    end

    // stage 2: astronomical year to BC/AD, no year zero
    assign w_neg = 25'd1 - r_s1.year;

    always_comb begin
        n_s2 = r_s1;
        if (r_s1.year[24] || r_s1.year == 25'd0) begin
            n_s2.bc = 1'b1;
            n_s2.yv = w_neg[23:0];
        end else begin
            n_s2.bc = 1'b0;
            n_s2.yv = r_s1.year[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s0 <= n_s0;
        end
        if (w_rdy[1]) begin
            r_s1 <= n_s1;
        end
        if (w_rdy[2]) begin
            r_s2 <= n_s2;
        end
    end

    assign o_ready         = w_rdy[0];
    assign o_valid         = r_v[2];
    assign o_day_of_month  = r_s2.dd;
    assign o_month_of_year = r_s2.mm;
    assign o_year_value    = r_s2.yv;
    assign o_before_christ = r_s2.bc;

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] |-> (r_s2.mm >= 4'd1 && r_s2.mm <= 4'd12))
        else $error("month out of range");

    a_day_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[1] |-> (r_s1.dd != 5'd0))
        else $error("day of month is zero");

endmodule

// File: design/julian_day_to_calendar_date.sv
// ----------------------------------------------------------------------------
// julian_day_to_calendar_date
// Day count since 1 Jan 4713 BC to day, month, year and BC flag.
// Throughput: one item per cycle while the output side accepts items; each
// stage holds while it is full and the next one cannot take its item.
// Reset (synchronous, active low) clears all stage valid bits.
// ----------------------------------------------------------------------------
module julian_day_to_calendar_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [31:0] day_number
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // [4:0] day_of_month, [8:5] month_of_year,
                                         // [32:9] year_value, [39:33] zero
    output logic        o_m_axis_tuser   // [0] before_christ
);

    jdcd_pkg::t_cycle      w_cyc;
    jdcd_pkg::t_march_date w_date;
    logic                  w_cyc_valid, w_cyc_ready;
    logic                  w_date_valid, w_date_ready;
    logic [4:0]            w_day;
    logic [3:0]            w_month;
    logic [23:0]           w_year;
    logic                  w_bc;

    jdcd_cycle u_cycle (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_day_number (i_s_axis_tdata),
        .o_valid      (w_cyc_valid),
        .i_ready      (w_cyc_ready),
        .o_data       (w_cyc)
    );

    jdcd_year u_year (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cyc_valid),
        .o_ready (w_cyc_ready),
        .i_data  (w_cyc),
        .o_valid (w_date_valid),
        .i_ready (w_date_ready),
        .o_data  (w_date)
    );

    jdcd_month u_month (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_date_valid),
        .o_ready         (w_date_ready),
        .i_data          (w_date),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_day_of_month  (w_day),
        .o_month_of_year (w_month),
        .o_year_value    (w_year),
        .o_before_christ (w_bc)
    );

    assign o_m_axis_tdata = {7'b0, w_year, w_month, w_day};
    assign o_m_axis_tuser = w_bc;

endmodule

// File: bench/jdcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdcd_checker
// Watches both streams of the day number to calendar date pipeline. Every
// accepted day number is converted here on its own into day, month, year
// and BC flag and queued; every accepted output item is compared field by
// field with the oldest queued date.
// ----------------------------------------------------------------------------
module jdcd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [31:0] day_number
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [39:0] i_m_axis_tdata,  // [4:0] day, [8:5] month, [32:9] year, [39:33] zero
    input  logic        i_m_axis_tuser,  // [0] before_christ
    output int          o_fail_count,
    output int          o_pending
);

    localparam longint LAST_JULIAN_DAY   = 2299160;
    localparam longint MARCH_ZERO_OFFSET = 1721120;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [23:0] year;
        logic        bc;
    } t_calendar_date;

    t_calendar_date expected_dates[$];

    function automatic t_calendar_date date_of_day(input logic [31:0] day_number);
        longint         d;
        longint         cyc;
        longint         r;
        longint         yoff;
        longint         ast;
        longint         era;
        longint         doe;
        longint         yoe;
        longint         doy;
        longint         mp;
        longint         dd;
        longint         mm;
        longint         len;
        longint         m;
        bit             leap;
        bit             found;
        t_calendar_date res;
        d = longint'(day_number);
        if (d <= LAST_JULIAN_DAY) begin
            // four-year cycles, each opening with a leap year
            cyc = d / 1461;
            r = d % 1461;
            if (r < 366) begin
                yoff = 0;
                leap = 1'b1;
            end else begin
                r = r - 366;
                yoff = 1 + r / 365;
                r = r % 365;
                leap = 1'b0;
            end
            m = 0;
            found = 1'b0;
            while (m < 11 && !found) begin
                if (m == 1)
                    len = leap ? 29 : 28;
                else if (m == 3 || m == 5 || m == 8 || m == 10)
                    len = 30;
                else
                    len = 31;
                if (r < len) begin
                    found = 1'b1;
                end else begin
                    r = r - len;
                    m = m + 1;
                end
            end
            ast = cyc * 4 + yoff - 4712;
            mm = m + 1;
            dd = r + 1;
        end else begin
            // Gregorian, days counted from 1 March of year 0
            d = d - MARCH_ZERO_OFFSET;
            era = d / 146097;
            doe = d - era * 146097;
            yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp = (5 * doy + 2) / 153;
            dd = doy - (153 * mp + 2) / 5 + 1;
            mm = (mp < 10) ? mp + 3 : mp - 9;
            ast = yoe + era * 400 + ((mm <= 2) ? 1 : 0);
        end
        // no year zero: astronomical 0 is 1 BC
        if (ast <= 0) begin
            res.year = 24'(1 - ast);
            res.bc = 1'b1;
        end else begin
            res.year = 24'(ast);
            res.bc = 1'b0;
        end
        res.day = 5'(dd);
        res.month = 4'(mm);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_calendar_date want;
        t_calendar_date got;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_dates.push_back(date_of_day(i_s_axis_tdata));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.day = i_m_axis_tdata[4:0];
                got.month = i_m_axis_tdata[8:5];
                got.year = i_m_axis_tdata[32:9];
                got.bc = i_m_axis_tuser;
                if (expected_dates.size() == 0) begin
                    $display("%0t: unexpected item day=%0d month=%0d year=%0d bc=%0d",
                             $time, got.day, got.month, got.year, got.bc);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_dates.pop_front();
                    if (got.day !== want.day)
                        $display("%0t: day mismatch, expected %0d, actual %0d",
                                 $time, want.day, got.day);
                    if (got.month !== want.month)
                        $display("%0t: month mismatch, expected %0d, actual %0d",
                                 $time, want.month, got.month);
                    if (got.year !== want.year)
                        $display("%0t: year mismatch, expected %0d, actual %0d",
                                 $time, want.year, got.year);
                    if (got.bc !== want.bc)
                        $display("%0t: bc mismatch, expected %0d, actual %0d",
                                 $time, want.bc, got.bc);
                    if (got !== want)
                        o_fail_count <= o_fail_count + 1;
                end
            end
            o_pending <= expected_dates.size();
        end
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives day numbers into the calendar date pipeline: calendar edges first,
// then random day numbers biased toward the Julian range and the calendar
// switch. Both sides idle at random; the output side also holds off for a
// long stretch to back the pipeline up. The checker gives the verdict data.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_ITEMS = 1530;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 32;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        day_valid = 1'b0;
    logic        day_ready;
    logic [31:0] day_data = 32'd0;
    logic        date_valid;
    logic        date_ready = 1'b0;
    logic [39:0] date_data;
    logic        date_user;
    logic        stim_done = 1'b0;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;

    always #10 clk = ~clk;

    julian_day_to_calendar_date u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (day_valid),
        .o_s_axis_tready (day_ready),
        .i_s_axis_tdata  (day_data),
        .o_m_axis_tvalid (date_valid),
        .i_m_axis_tready (date_ready),
        .o_m_axis_tdata  (date_data),
        .o_m_axis_tuser  (date_user)
    );

    jdcd_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (day_valid),
        .i_s_axis_tready (day_ready),
        .i_s_axis_tdata  (day_data),
        .i_m_axis_tvalid (date_valid),
        .i_m_axis_tready (date_ready),
        .i_m_axis_tdata  (date_data),
        .i_m_axis_tuser  (date_user),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    task automatic send_day(input logic [31:0] dn, input bit may_idle);
        if (may_idle) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                day_valid <= 1'b0;
                @(posedge clk);
            end
        end
        day_valid <= 1'b1;
        day_data <= dn;
        @(posedge clk);
        while (!day_ready)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_day();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            return $urandom();
        else if (pick < 65)
            return $urandom_range(0, 2299160);
        else if (pick < 80)
            return $urandom_range(2299160 - 3000, 2299160 + 3000);
        else if (pick < 90)
            return $urandom_range(1721424 - 2000, 1721424 + 2000);
        else
            return $urandom_range(2299161, 5373484);
    endfunction

    // reset
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // input side
    initial begin
        logic [31:0] edge_days[$];
        edge_days = '{32'd0, 32'd58, 32'd59, 32'd365, 32'd366, 32'd1460, 32'd1461,
                      32'd1721057, 32'd1721423, 32'd1721424, 32'd2299159,
                      32'd2299160, 32'd2299161, 32'd2299162, 32'd2451604,
                      32'd2451605, 32'h7FFFFFFF, 32'h80000000, 32'h55555555,
                      32'hAAAAAAAA, 32'hFFFFFFFE, 32'hFFFFFFFF};
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        foreach (edge_days[i])
            send_day(edge_days[i], 1'b1);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_day(random_day(), !(i >= 600 && i < 900));
        day_valid <= 1'b0;
        stim_done <= 1'b1;
    end

    // output side: long hold-off early, then a stretch without idling
    initial begin
        int n;
        n = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (n >= 60 && n < 260)
                date_ready <= 1'b0;
            else if (n >= 1500 && n < 2100)
                date_ready <= 1'b1;
            else
                date_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            n++;
            @(posedge clk);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // verdict
    initial begin
        wait (stim_done);
        do
            @(posedge clk);
        while (pending != 0);
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: julian_day_to_calendar_date.f
design/jdcd_pkg.sv
design/jdcd_cycle.sv
design/jdcd_year.sv
design/jdcd_month.sv
design/julian_day_to_calendar_date.sv
bench/jdcd_checker.sv
bench/tb_top.sv
